FILE: rtl/core/mst_pkg.sv
`timescale 1ns / 1ps

package mst_pkg;

   localparam int DEPTH_DEFAULT      = 256;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int STATUS_W           = 2;

   // Request mode codes.
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOAD = 2'b10
   } state_type;

endpackage

FILE: rtl/core/mst_req_if.sv
`timescale 1ns / 1ps

interface mst_req_if
   import mst_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

FILE: rtl/core/mst_rsp_if.sv
`timescale 1ns / 1ps

interface mst_rsp_if
   import mst_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int COUNT_W    = $clog2(DEPTH_DEFAULT + 1)
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] top_value;
   logic                         top_valid;
   logic signed [DATA_WIDTH-1:0] min_value;
   logic                         min_valid;
   logic [COUNT_W-1:0]           count;
   logic [STATUS_W-1:0]          status;

   modport source (output valid, output top_value, output top_valid, output min_value,
                   output min_valid, output count, output status, input ready);
   modport sink   (input valid, input top_value, input top_valid, input min_value,
                   input min_valid, input count, input status, output ready);
endinterface

FILE: rtl/core/min_stack_tracker_top.sv
`timescale 1ns / 1ps

// Stack of signed values that also reports its current minimum. Each request
// either pushes a value or pops the top, and produces exactly one response with
// the top, the minimum, their valid flags, the count and a status; a push to a
// full stack or a pop from an empty one leaves the stack unchanged and is flagged.
// A push or a refused request has its response registered at the edge that
// accepts it. A successful pop first passes through a read-back state, as the
// new top and the new minimum are read back from the value and minimum memories,
// whose reads are registered. One request is in flight at a time, and
// a new request is taken once the response register is free or being emptied.
// The memories need no clearing pass after reset; only counts and control state are reset.

module min_stack_tracker_top
   import mst_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mst_req_if.sink    req_if,
   mst_rsp_if.source  rsp_if
);

   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

   state_type state_ff, state_in;
   logic [COUNT_W-1:0] value_count_ff, value_count_in;
   logic [COUNT_W-1:0] min_count_ff, min_count_in;
   logic signed [DATA_WIDTH-1:0] top_ff, top_in;
   logic signed [DATA_WIDTH-1:0] min_top_ff, min_top_in;
   logic min_pop_ff, min_pop_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] out_top_ff, out_top_in;
   logic out_top_valid_ff, out_top_valid_in;
   logic signed [DATA_WIDTH-1:0] out_min_ff, out_min_in;
   logic out_min_valid_ff, out_min_valid_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;

   logic val_we, min_we;
   logic [ADDR_W-1:0] val_waddr, min_waddr, val_raddr, min_raddr;
   logic [DATA_WIDTH-1:0] val_rdata, min_rdata;
   logic [COUNT_W-1:0] val_below, min_below;

   logic req_ready, accept, present;
   logic [STATUS_W-1:0] status;

   mst_stack_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_value_mem (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (req_if.value),
      .rd_addr (val_raddr),
      .rd_data (val_rdata)
   );

   mst_stack_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_min_mem (
      .clock   (clock),
      .wr_en   (min_we),
      .wr_addr (min_waddr),
      .wr_data (req_if.value),
      .rd_addr (min_raddr),
      .rd_data (min_rdata)
   );

   // The cached tops sit at count-1, so the entry below them is at count-2.
   assign val_below = value_count_ff - COUNT_W'(2);
   assign min_below = min_count_ff - COUNT_W'(2);
   assign val_raddr = val_below[ADDR_W-1:0];
   assign min_raddr = min_below[ADDR_W-1:0];
   assign val_waddr = value_count_ff[ADDR_W-1:0];
   assign min_waddr = min_count_ff[ADDR_W-1:0];

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept    = req_if.valid && req_ready;

   always_comb begin
      state_in         = state_ff;
      value_count_in   = value_count_ff;
      min_count_in     = min_count_ff;
      top_in           = top_ff;
      min_top_in       = min_top_ff;
      min_pop_in       = min_pop_ff;
      val_we           = 1'b0;
      min_we           = 1'b0;
      present          = 1'b0;
      status           = STATUS_DONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.mode == MODE_PUSH) begin
                  present = 1'b1;
                  if (value_count_ff == COUNT_FULL) begin
                     status = STATUS_PUSH_FULL;
                  end else begin
                     val_we         = 1'b1;
                     value_count_in = value_count_ff + COUNT_W'(1);
                     top_in         = req_if.value;
                     // Equal values are recorded too, so duplicate minima survive pops.
                     if (min_count_ff != COUNT_FULL &&
                         (min_count_ff == '0 || req_if.value <= min_top_ff)) begin
                        min_we       = 1'b1;
                        min_count_in = min_count_ff + COUNT_W'(1);
                        min_top_in   = req_if.value;
                     end
                  end
               end else if (value_count_ff == '0) begin
                  present = 1'b1;
                  status  = STATUS_POP_EMPTY;
               end else begin
                  value_count_in = value_count_ff - COUNT_W'(1);
                  min_pop_in     = (min_count_ff != '0) && (top_ff == min_top_ff);
                  if (min_pop_in) begin
                     min_count_in = min_count_ff - COUNT_W'(1);
                  end
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            top_in = val_rdata;
            if (min_pop_ff) begin
               min_top_in = min_rdata;
            end
            present  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_if.ready;
      out_top_in       = out_top_ff;
      out_top_valid_in = out_top_valid_ff;
      out_min_in       = out_min_ff;
      out_min_valid_in = out_min_valid_ff;
      out_count_in     = out_count_ff;
      out_status_in    = out_status_ff;
      if (present) begin
         rsp_valid_in     = 1'b1;
         out_top_valid_in = value_count_in != '0;
         out_top_in       = out_top_valid_in ? top_in : '0;
         out_min_valid_in = min_count_in != '0;
         out_min_in       = out_min_valid_in ? min_top_in : '0;
         out_count_in     = value_count_in;
         out_status_in    = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         value_count_ff <= '0;
         min_count_ff   <= '0;
         min_pop_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         value_count_ff <= value_count_in;
         min_count_ff   <= min_count_in;
         min_pop_ff     <= min_pop_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff           <= top_in;
      min_top_ff       <= min_top_in;
      out_top_ff       <= out_top_in;
      out_top_valid_ff <= out_top_valid_in;
      out_min_ff       <= out_min_in;
      out_min_valid_ff <= out_min_valid_in;
      out_count_ff     <= out_count_in;
      out_status_ff    <= out_status_in;
   end

   assign req_if.ready     = req_ready;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.top_value = out_top_ff;
   assign rsp_if.top_valid = out_top_valid_ff;
   assign rsp_if.min_value = out_min_ff;
   assign rsp_if.min_valid = out_min_valid_ff;
   assign rsp_if.count     = out_count_ff;
   assign rsp_if.status    = out_status_ff;

   // The minimum stack never holds more entries than the value stack.
   a_min_le_value: assert property (@(posedge clock) disable iff (reset)
      min_count_ff <= value_count_ff)
      else $error("minimum count exceeds value count");

   // A nonempty stack always has a recorded minimum.
   a_min_exists: assert property (@(posedge clock) disable iff (reset)
      value_count_ff != '0 |-> min_count_ff != '0)
      else $error("nonempty stack without a minimum");

   // The read-back cycle always finds the response register free.
   a_load_out_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> !rsp_valid_ff)
      else $error("response register busy during pop read-back");

   // A successful pop is answered in the cycle after its read-back.
   a_pop_answer: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> rsp_valid_ff && out_status_ff == STATUS_DONE)
      else $error("pop response missing");

endmodule

FILE: rtl/core/mst_stack_mem.sv
`timescale 1ns / 1ps

module mst_stack_mem
   import mst_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
